### sv/cop_pkg.sv
package cop_pkg;

	localparam int unsigned OFFSET_W = 19;

	localparam logic [13:0] COUNT_MAX = 14'd9999;

	typedef logic [3:0] bcd_t;

	typedef struct packed {
		bcd_t [3:0] digit;
		logic [2:0] count;
	} digit_info_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	localparam rgb_t COL_BODY      = '{r: 8'd24,  g: 8'd28,  b: 8'd38};
	localparam rgb_t COL_BORDER    = '{r: 8'd70,  g: 8'd76,  b: 8'd90};
	localparam rgb_t COL_COIN      = '{r: 8'd244, g: 8'd190, b: 8'd48};
	localparam rgb_t COL_HIGHLIGHT = '{r: 8'd255, g: 8'd232, b: 8'd112};
	localparam rgb_t COL_DIGIT     = '{r: 8'd250, g: 8'd250, b: 8'd246};
	localparam rgb_t COL_NONE      = '{r: 8'd0,   g: 8'd0,   b: 8'd0};

	// segment order: a (bit 0) through g (bit 6)
	function automatic logic [6:0] seg_mask(input bcd_t d);
		logic [6:0] m;
		case (d)
			4'd0: m = 7'h3F;
			4'd1: m = 7'h06;
			4'd2: m = 7'h5B;
			4'd3: m = 7'h4F;
			4'd4: m = 7'h66;
			4'd5: m = 7'h6D;
			4'd6: m = 7'h7D;
			4'd7: m = 7'h07;
			4'd8: m = 7'h7F;
			4'd9: m = 7'h6F;
			default: m = 7'h00;
		endcase
		return m;
	endfunction

endpackage

### sv/cop_digits.sv
module cop_digits (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  logic signed [15:0]  value,
	output logic                busy,
	output cop_pkg::digit_info_t info
);

	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [13:0] bin_q;
	logic [15:0] bcd_q;
	logic [13:0] clamped;
	logic [15:0] adj;

	// clamp to 0..9999
	always_comb begin
		if (value[15]) begin
			clamped = '0;
		end else if (value > 16'sd9999) begin
			clamped = cop_pkg::COUNT_MAX;
		end else begin
			clamped = value[13:0];
		end
	end

	// double dabble: add 3 to each digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			bin_q  <= '0;
			bcd_q  <= '0;
		end else if (wr) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			bin_q  <= clamped;
			bcd_q  <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[14:0], bin_q[13]};
			bin_q <= {bin_q[12:0], 1'b0};
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd13) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;

	always_comb begin
		info.digit = bcd_q;
		if (bcd_q[15:12] != 4'd0) begin
			info.count = 3'd4;
		end else if (bcd_q[11:8] != 4'd0) begin
			info.count = 3'd3;
		end else if (bcd_q[7:4] != 4'd0) begin
			info.count = 3'd2;
		end else begin
			info.count = 3'd1;
		end
	end

endmodule

### sv/cop_shade.sv
module cop_shade (
	input  logic                 on_screen,
	input  logic [8:0]           x,
	input  logic [7:0]           y,
	input  cop_pkg::digit_info_t info,
	output logic                 covered,
	output cop_pkg::rgb_t        color
);

	function automatic logic seg_lit(input logic [6:0] m, input logic [3:0] lx,
		input logic [4:0] ly);
		logic mid, right, left;
		logic top, upper, midrow, lower, bottom;
		mid    = (lx >= 4'd2) && (lx <= 4'd7);
		right  = (lx >= 4'd8) && (lx <= 4'd9);
		left   = (lx <= 4'd1);
		top    = (ly <= 5'd1);
		upper  = (ly >= 5'd2) && (ly <= 5'd7);
		midrow = (ly >= 5'd8) && (ly <= 5'd9);
		lower  = (ly >= 5'd10) && (ly <= 5'd15);
		bottom = (ly >= 5'd16) && (ly <= 5'd17);
		return (m[0] && mid && top) || (m[1] && right && upper)
			|| (m[2] && right && lower) || (m[3] && mid && bottom)
			|| (m[4] && left && lower) || (m[5] && left && upper)
			|| (m[6] && mid && midrow);
	endfunction

	logic              border_hit, body_hit, coin_box, disc_hit, hl_hit, bar_hit;
	logic [8:0]        xd;
	logic [7:0]        yd;
	logic signed [4:0] dx, dy;
	logic signed [9:0] sqx, sqy;
	logic [7:0]        dsq;
	logic              dig_area, digit_hit;
	logic [8:0]        u;
	logic [1:0]        idx;
	logic [8:0]        ubase;
	logic [3:0]        lx;
	logic [4:0]        ly;
	logic [1:0]        pos;
	cop_pkg::bcd_t     dsel;

	assign border_hit = (x >= 9'd8) && (x <= 9'd85) && (y >= 8'd8) && (y <= 8'd35);
	assign body_hit   = (x >= 9'd10) && (x <= 9'd83) && (y >= 8'd10) && (y <= 8'd33);

	// coin disc around (23,22)
	assign coin_box = (x >= 9'd15) && (x <= 9'd31) && (y >= 8'd14) && (y <= 8'd30);
	assign xd  = x - 9'd23;
	assign yd  = y - 8'd22;
	assign dx  = xd[4:0];
	assign dy  = yd[4:0];
	assign sqx = dx * dx;
	assign sqy = dy * dy;
	assign dsq = sqx[7:0] + sqy[7:0];
	assign disc_hit = coin_box && (dsq <= 8'd64);
	assign hl_hit   = coin_box && (dsq <= 8'd25) && (dx[4] || (dx == 5'sd0))
		&& (dy[4] || (dy == 5'sd0));

	assign bar_hit = (x >= 9'd22) && (x <= 9'd23) && (y >= 8'd17) && (y <= 8'd26);

	// digit cells are 13 columns apart starting at column 38
	assign dig_area = (x >= 9'd38) && (x < 9'd90) && (y >= 8'd13) && (y <= 8'd30);
	assign u = x - 9'd38;

	always_comb begin
		if (u < 9'd13) begin
			idx   = 2'd0;
			ubase = 9'd0;
		end else if (u < 9'd26) begin
			idx   = 2'd1;
			ubase = 9'd13;
		end else if (u < 9'd39) begin
			idx   = 2'd2;
			ubase = 9'd26;
		end else begin
			idx   = 2'd3;
			ubase = 9'd39;
		end
	end

	always_comb begin
		logic [8:0] ld;
		logic [7:0] yl;
		logic [2:0] p;
		ld   = u - ubase;
		yl   = y - 8'd13;
		p    = info.count - 3'd1 - {1'b0, idx};
		lx   = ld[3:0];
		ly   = yl[4:0];
		pos  = p[1:0];
		dsel = info.digit[pos];
	end

	assign digit_hit = dig_area && (lx < 4'd10) && ({1'b0, idx} < info.count)
		&& seg_lit(cop_pkg::seg_mask(dsel), lx, ly);

	always_comb begin
		covered = 1'b0;
		color   = cop_pkg::COL_NONE;
		if (on_screen) begin
			if (digit_hit) begin
				covered = 1'b1;
				color   = cop_pkg::COL_DIGIT;
			end else if (bar_hit) begin
				covered = 1'b1;
				color   = cop_pkg::COL_BORDER;
			end else if (hl_hit) begin
				covered = 1'b1;
				color   = cop_pkg::COL_HIGHLIGHT;
			end else if (disc_hit) begin
				covered = 1'b1;
				color   = cop_pkg::COL_COIN;
			end else if (body_hit) begin
				covered = 1'b1;
				color   = cop_pkg::COL_BODY;
			end else if (border_hit) begin
				covered = 1'b1;
				color   = cop_pkg::COL_BORDER;
			end
		end
	end

endmodule

### sv/counter_overlay_pixel_generator.sv
// pixel path: coordinates registered in stage s1, color and offset registered in stage s2, which drives the outputs
// throughput: one pixel per cycle, limited by out_ready backpressure and by a running decimal conversion
// a counter_value write starts a decimal conversion; no pixel is taken meanwhile
// reset (arst_n low, asynchronous): pipeline empty, displayed value 0
module counter_overlay_pixel_generator #(
	parameter int unsigned SCREEN_HEIGHT = 240,
	parameter int unsigned SCREEN_WIDTH  = 400
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic signed [15:0]                    counter_value,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [8:0]                            pixel_x,
	input  logic [7:0]                            pixel_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  covered,
	output logic [7:0]                            red,
	output logic [7:0]                            green,
	output logic [7:0]                            blue,
	output logic [cop_pkg::OFFSET_W-1:0]          byte_offset
);

	localparam int unsigned OW = cop_pkg::OFFSET_W;

	logic                 busy;
	cop_pkg::digit_info_t info;
	logic                 ld_s1, ld_s2;
	logic                 v_s1, v_s2;
	logic [8:0]           x_s1;
	logic [7:0]           y_s1;
	logic                 on_screen;
	logic                 cov_c;
	cop_pkg::rgb_t        col_c;
	logic [OW-1:0]        x_ext, prod, lin, off_c;
	logic                 cov_s2;
	cop_pkg::rgb_t        col_s2;
	logic [OW-1:0]        off_s2;

	assign cfg_ready = 1'b1;

	cop_digits u_digits (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid && cfg_ready),
		.value  (counter_value),
		.busy   (busy),
		.info   (info)
	);

	assign ld_s2    = !v_s2 || out_ready;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_ready = ld_s1 && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= in_valid && in_ready;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid && in_ready) begin
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;
		end
		if (ld_s2 && v_s1) begin
			cov_s2 <= cov_c;
			col_s2 <= col_c;
			off_s2 <= off_c;
		end
	end

	assign on_screen = ({2'b00, x_s1} < 11'(SCREEN_WIDTH))
		&& ({3'b000, y_s1} < 11'(SCREEN_HEIGHT));

	cop_shade u_shade (
		.on_screen (on_screen),
		.x         (x_s1),
		.y         (y_s1),
		.info      (info),
		.covered   (cov_c),
		.color     (col_c)
	);

	// column-rotated offset: 3 * (x * height + height - 1 - y), low bits kept; 0 for an off-screen pixel
	assign x_ext = OW'(x_s1);
	assign prod  = x_ext * OW'(SCREEN_HEIGHT);
	assign lin   = prod + OW'(SCREEN_HEIGHT - 1) - OW'(y_s1);
	assign off_c = on_screen ? lin + {lin[OW-2:0], 1'b0} : '0;

	assign out_valid   = v_s2;
	assign covered     = cov_s2;
	assign red         = col_s2.r;
	assign green       = col_s2.g;
	assign blue        = col_s2.b;
	assign byte_offset = off_s2;

endmodule

### sv/cop_checker.sv
module cop_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         covered,
	input logic [7:0]                   red,
	input logic [7:0]                   green,
	input logic [7:0]                   blue,
	input logic [cop_pkg::OFFSET_W-1:0] byte_offset
);

	logic [23:0] rgb;
	assign rgb = {red, green, blue};

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(covered) && $stable(rgb)
			&& $stable(byte_offset))
		else $error("result changed while stalled");

	// uncovered pixel carries black
	a_uncovered_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !covered |-> rgb == cop_pkg::COL_NONE)
		else $error("uncovered pixel has color");

	// covered pixel uses one of the overlay colors
	a_covered_palette: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && covered |-> rgb == cop_pkg::COL_BODY || rgb == cop_pkg::COL_BORDER
			|| rgb == cop_pkg::COL_COIN || rgb == cop_pkg::COL_HIGHLIGHT
			|| rgb == cop_pkg::COL_DIGIT)
		else $error("covered pixel color outside palette");

	// a covered pixel never comes out with both offset and color all zero
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && covered |-> byte_offset != '0 || rgb != cop_pkg::COL_NONE)
		else $error("covered pixel without offset or color");

endmodule

bind counter_overlay_pixel_generator cop_checker u_cop_checker (.*);

### tb/tb_counter_overlay_pixel_generator.sv
module tb_counter_overlay_pixel_generator;

	typedef struct packed {
		logic                         covered;
		cop_pkg::rgb_t                color;
		logic [cop_pkg::OFFSET_W-1:0] offset;
	} pixel_result_t;

	class pixel_scoreboard;
		localparam int SCREEN_W = 400;
		localparam int SCREEN_H = 240;
		localparam logic [69:0] DIGIT_SEGS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
			7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};
		localparam cop_pkg::rgb_t PANEL_BODY = {8'd24, 8'd28, 8'd38};
		localparam cop_pkg::rgb_t PANEL_EDGE = {8'd70, 8'd76, 8'd90};
		localparam cop_pkg::rgb_t COIN_GOLD  = {8'd244, 8'd190, 8'd48};
		localparam cop_pkg::rgb_t COIN_SHINE = {8'd255, 8'd232, 8'd112};
		localparam cop_pkg::rgb_t DIGIT_INK  = {8'd250, 8'd250, 8'd246};

		pixel_result_t expected_pixels [$];
		int shown_value;
		int mismatches;
		int checked;
		int covered_seen;

		function new();
			shown_value = 0;
			mismatches = 0;
			checked = 0;
			covered_seen = 0;
		endfunction

		function void set_counter(logic signed [15:0] v);
			shown_value = v;
		endfunction

		function bit in_rect(int x, int y, int x0, int y0, int w, int h);
			return x >= x0 && x < x0 + w && y >= y0 && y < y0 + h;
		endfunction

		function bit segment_on(logic [6:0] m, int lx, int ly);
			return (m[0] && in_rect(lx, ly, 2, 0, 6, 2)) ||
				(m[1] && in_rect(lx, ly, 8, 2, 2, 6)) ||
				(m[2] && in_rect(lx, ly, 8, 10, 2, 6)) ||
				(m[3] && in_rect(lx, ly, 2, 16, 6, 2)) ||
				(m[4] && in_rect(lx, ly, 0, 10, 2, 6)) ||
				(m[5] && in_rect(lx, ly, 0, 2, 2, 6)) ||
				(m[6] && in_rect(lx, ly, 2, 8, 6, 2));
		endfunction

		function pixel_result_t overlay_pixel(int x, int y);
			pixel_result_t p;
			logic [31:0] off_full;
			int dx, dy, d, v, n, idx, lx, k;
			int dig [4];
			p = '0;
			if (x >= SCREEN_W || y >= SCREEN_H) begin
				return p;
			end
			off_full = 3 * (x * SCREEN_H + SCREEN_H - 1 - y);
			p.offset = off_full[cop_pkg::OFFSET_W-1:0];
			if (in_rect(x, y, 8, 8, 78, 28)) begin
				p.covered = 1'b1;
				p.color = PANEL_EDGE;
			end
			if (in_rect(x, y, 10, 10, 74, 24)) begin
				p.covered = 1'b1;
				p.color = PANEL_BODY;
			end
			dx = x - 23;
			dy = y - 22;
			if (dx >= -8 && dx <= 8 && dy >= -8 && dy <= 8) begin
				d = dx * dx + dy * dy;
				if (d <= 64) begin
					p.covered = 1'b1;
					p.color = COIN_GOLD;
				end
				if (d <= 25 && dx <= 0 && dy <= 0) begin
					p.covered = 1'b1;
					p.color = COIN_SHINE;
				end
			end
			if (in_rect(x, y, 22, 17, 2, 10)) begin
				p.covered = 1'b1;
				p.color = PANEL_EDGE;
			end
			v = shown_value;
			if (v < 0) v = 0;
			if (v > 9999) v = 9999;
			if (v >= 1000) n = 4;
			else if (v >= 100) n = 3;
			else if (v >= 10) n = 2;
			else n = 1;
			for (k = n - 1; k >= 0; k--) begin
				dig[k] = v % 10;
				v = v / 10;
			end
			if (x >= 38 && y >= 13 && y < 31) begin
				idx = (x - 38) / 13;
				lx = (x - 38) % 13;
				if (idx < n && lx < 10) begin
					if (segment_on(DIGIT_SEGS[dig[idx]*7 +: 7], lx, y - 13)) begin
						p.covered = 1'b1;
						p.color = DIGIT_INK;
					end
				end
			end
			return p;
		endfunction

		function void note_pixel(int x, int y);
			expected_pixels.push_back(overlay_pixel(x, y));
		endfunction

		function void check_result(pixel_result_t got);
			pixel_result_t want;
			checked++;
			if (got.covered) covered_seen++;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("extra result: cov=%0d rgb=%0d,%0d,%0d off=%0d",
						got.covered, got.color.r, got.color.g, got.color.b, got.offset);
				return;
			end
			want = expected_pixels.pop_front();
			if (got.covered !== want.covered || got.color.r !== want.color.r ||
				got.color.g !== want.color.g || got.color.b !== want.color.b ||
				got.offset !== want.offset) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at result %0d: exp cov=%0d rgb=%0d,%0d,%0d off=%0d",
						checked, want.covered, want.color.r, want.color.g, want.color.b,
						want.offset);
					$display("    got cov=%0d rgb=%0d,%0d,%0d off=%0d",
						got.covered, got.color.r, got.color.g, got.color.b, got.offset);
				end
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_ITEMS = 70;
	localparam int DIR_N = 26;
	localparam int SETTING_N = 16;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic signed [15:0]           counter_value;
	logic                         in_valid;
	logic                         in_ready;
	logic [8:0]                   pixel_x;
	logic [7:0]                   pixel_y;
	logic                         out_valid;
	logic                         out_ready;
	logic                         covered;
	logic [7:0]                   red;
	logic [7:0]                   green;
	logic [7:0]                   blue;
	logic [cop_pkg::OFFSET_W-1:0] byte_offset;

	pixel_scoreboard sb = new();
	int sender_idle;
	int receiver_idle;
	int pixels_sent;
	int stall_cycles;
	int settings_done;

	int dir_x [DIR_N] = '{0, 399, 400, 0, 511, 399, 0, 8, 85, 86, 7, 10, 83, 23, 31, 32,
		20, 18, 26, 22, 23, 22, 40, 47, 38, 51};
	int dir_y [DIR_N] = '{0, 239, 0, 240, 255, 0, 239, 8, 35, 35, 20, 10, 33, 22, 22, 22,
		19, 17, 25, 17, 26, 27, 13, 20, 28, 20};
	logic signed [15:0] counter_settings [SETTING_N] = '{16'sd8888, -16'sd32768, 16'sd32767,
		16'sd9999, 16'sd10000, 16'sd1000, 16'sd999, 16'sd100, 16'sd99, 16'sd10, 16'sd9,
		16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0};

	counter_overlay_pixel_generator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.counter_value (counter_value),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.covered       (covered),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.byte_offset   (byte_offset)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial out_ready <= 1'b0;

	always @(posedge clk) begin
		out_ready <= (receiver_idle == 0) || ($urandom_range(0, 99) >= receiver_idle);
	end

	// transfer monitor and stall watchdog
	always @(posedge clk) begin
		pixel_result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_counter(counter_value);
			if (in_valid && in_ready)
				sb.note_pixel(pixel_x, pixel_y);
			if (out_valid && out_ready) begin
				got.covered = covered;
				got.color = {red, green, blue};
				got.offset = byte_offset;
				sb.check_result(got);
			end
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", stall_cycles);
				$display("FAIL counter_overlay_pixel_generator");
				$finish;
			end
		end
	end

	task automatic send_pixel(input logic [8:0] x, input logic [7:0] y);
		if (pixels_sent < 400) begin
			sender_idle = 37;
			receiver_idle = 74;
		end else if (pixels_sent < 800) begin
			sender_idle = 74;
			receiver_idle = 37;
		end else begin
			sender_idle = 0;
			receiver_idle = 0;
		end
		while (sender_idle != 0 && $urandom_range(0, 99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
	endtask

	task automatic send_random_pixel();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			send_pixel(9'($urandom_range(0, 95)), 8'($urandom_range(0, 40)));
		else if (pick < 90)
			send_pixel(9'($urandom_range(0, 399)), 8'($urandom_range(0, 239)));
		else
			send_pixel(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_counter(input logic signed [15:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		counter_value <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		counter_value <= '0;
		in_valid <= 1'b0;
		pixel_x <= '0;
		pixel_y <= '0;
		sender_idle = 37;
		receiver_idle = 74;
		pixels_sent = 0;
		stall_cycles = 0;
		settings_done = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_pixel(9'(dir_x[i]), 8'(dir_y[i]));
		repeat (PHASE_ITEMS) send_random_pixel();

		for (int s = 0; s < SETTING_N; s++) begin
			if (s >= SETTING_N - 4)
				write_counter(16'($urandom_range(0, 65535)));
			else
				write_counter(counter_settings[s]);
			repeat (PHASE_ITEMS) send_random_pixel();
		end

		drain_results();
		repeat (10) @(posedge clk);
		$display("checked %0d pixels (%0d covered by the overlay) across %0d counter writes",
			sb.checked, sb.covered_seen, settings_done);
		$display("stimulus: corners, panel, coin, bar and digit edges, off-screen and random");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASS counter_overlay_pixel_generator");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
			$display("FAIL counter_overlay_pixel_generator");
		end
		$finish;
	end

endmodule

### filelist.f
sv/cop_pkg.sv
sv/cop_digits.sv
sv/cop_shade.sv
sv/counter_overlay_pixel_generator.sv
sv/cop_checker.sv
tb/tb_counter_overlay_pixel_generator.sv
